### rtl/fal_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fal_pkg
// shared types and constants for the frame audio level block
// ----------------------------------------------------------------------------
package fal_pkg;

  localparam int CFG_W     = 13;   // frame_length register width
  localparam int LEVEL_W   = 7;    // level_dbov width
  localparam int FRAC_BITS = 24;   // fraction bits of the log2 result
  localparam int MANT_W    = 31;   // log2 mantissa, q1.30
  localparam int K_W       = 26;   // width of the dB scale factor
  localparam int RND_POS   = 48;   // binary point of the scaled level
  localparam int CNT_W     = 5;    // fraction bit counter

  // round(10*log10(2) * 2^24)
  localparam logic [K_W-1:0]     LOG_K         = 26'd50504453;
  localparam logic [CFG_W-1:0]   FRAME_LEN_RST = 13'd960;
  localparam logic [LEVEL_W-1:0] LEVEL_SILENT  = 7'd127;
  localparam logic [LEVEL_W-1:0] LEVEL_FULL    = 7'd0;
  localparam logic [CNT_W-1:0]   FRAC_LAST     = 5'(FRAC_BITS - 1);

  typedef enum logic [3:0] {
    ST_RUN,
    ST_ADD,
    ST_CHK,
    ST_NORM,
    ST_FRAC,
    ST_NEXT,
    ST_DIFF,
    ST_MUL,
    ST_OUT
  } fal_state_t;

  // log2 unit commands
  typedef struct packed {
    logic load;
    logic shift;
    logic iter;
  } fal_lg_cmd_t;

  // controller to datapath
  typedef struct packed {
    logic take;      // sample transfer this cycle
    logic chk;       // latch silence / full-scale flags
    logic ld_len;    // start log2 of the frame length
    logic ld_sum;    // start log2 of the energy sum
    logic shift;     // one normalize step
    logic iter;      // one fraction bit
    logic save_len;  // keep log2 of the frame length
    logic diff;      // form the log difference
    logic mul;       // scale to db
    logic emit;      // load the level register, clear the sum
  } fal_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last;       // current sample closes the frame
    logic sum_zero;
    logic sum_full;
    logic norm_done;
  } fal_sts_t;

endpackage
`default_nettype wire

### rtl/fal_sample_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fal_sample_if
// sample channel: valid/ready handshake with one signed sample
// ----------------------------------------------------------------------------
interface fal_sample_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface
`default_nettype wire

### rtl/fal_level_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fal_level_if
// level channel: valid/ready handshake with one frame level
// ----------------------------------------------------------------------------
interface fal_level_if;
  logic                        valid;
  logic                        ready;
  logic [fal_pkg::LEVEL_W-1:0] level_dbov;

  modport source (output valid, output level_dbov, input ready);
  modport sink (input valid, input level_dbov, output ready);
endinterface
`default_nettype wire

### rtl/fal_log2.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fal_log2
// iterative log2 in q.24: bit-serial normalize, then one squaring per bit
// ----------------------------------------------------------------------------
module fal_log2 #(
  parameter int NORM_W = 43
) (
  input  logic                                       clk,
  input  fal_pkg::fal_lg_cmd_t                       cmd,
  input  logic [NORM_W-1:0]                          load_val,
  output logic                                       norm_done,
  output logic [$clog2(NORM_W)+fal_pkg::FRAC_BITS-1:0] result
);
  import fal_pkg::*;

  localparam int E_W = $clog2(NORM_W);

  logic [NORM_W-1:0]    x_r;
  logic [E_W-1:0]       e_r;
  logic [MANT_W-1:0]    y_r;
  logic [FRAC_BITS-1:0] frac_r;

  logic [2*MANT_W-1:0]  ysq;
  logic [MANT_W:0]      yn;
  logic                 fbit;
  logic [MANT_W-1:0]    y_nxt;

  always_comb begin
    ysq   = (2*MANT_W)'(y_r) * (2*MANT_W)'(y_r);
    yn    = ysq[2*MANT_W-1:MANT_W-1];
    fbit  = yn[MANT_W];
    y_nxt = fbit ? yn[MANT_W:1] : yn[MANT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r <= load_val;
      e_r <= E_W'(NORM_W - 1);
    end else if (cmd.shift) begin
      x_r <= x_r << 1;
      e_r <= e_r - 1'b1;
    end
    // mantissa follows the normalized word until the fraction loop runs
    if (cmd.iter) begin
      y_r    <= y_nxt;
      frac_r <= {frac_r[FRAC_BITS-2:0], fbit};
    end else begin
      y_r <= x_r[NORM_W-1 -: MANT_W];
    end
  end

  assign norm_done = x_r[NORM_W-1];
  assign result    = {e_r, frac_r};

endmodule
`default_nettype wire

### rtl/fal_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fal_dpath
// energy accumulator, frame counter, log difference and db scaling
// ----------------------------------------------------------------------------
module fal_dpath #(
  parameter int MAX_FRAME_LEN = 4096,
  parameter int SAMPLE_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [fal_pkg::CFG_W-1:0]     cfg_wr_data,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  fal_pkg::fal_cmd_t             cmd,
  output fal_pkg::fal_sts_t             sts,
  output logic [fal_pkg::LEVEL_W-1:0]   level_dbov
);
  import fal_pkg::*;

  localparam int LEN_W    = $clog2(MAX_FRAME_LEN + 1);
  localparam int FS_SHIFT = 2 * (SAMPLE_BITS - 1);
  localparam int SUM_W    = FS_SHIFT + LEN_W;
  localparam int SQ_W     = 2 * SAMPLE_BITS;
  localparam int NORM_W   = (SUM_W > MANT_W) ? SUM_W : MANT_W;
  localparam int LOG_W    = $clog2(NORM_W) + FRAC_BITS;
  localparam int D_W      = $clog2(NORM_W + FS_SHIFT) + FRAC_BITS;
  localparam int V_W      = D_W + K_W;
  localparam int HI_W     = V_W + 1 - RND_POS;

  logic [CFG_W-1:0]       frame_len_r;
  logic [LEN_W-1:0]       eff_len;
  logic [LEN_W-1:0]       idx_r;
  logic [LEN_W:0]         idx_inc;
  logic [SAMPLE_BITS-1:0] mag;
  logic [SQ_W-1:0]        sq_r;
  logic                   sq_vld_r;
  logic [SUM_W-1:0]       acc_r, acc_nxt;
  logic                   zero_r, full_r;

  fal_lg_cmd_t            lg_cmd;
  logic [NORM_W-1:0]      lg_val;
  logic                   lg_norm;
  logic [LOG_W-1:0]       lg_res;
  logic [LOG_W-1:0]       l_len_r;

  logic [D_W-1:0]         num, den, d_r;
  logic [V_W-1:0]         v_r;
  logic [V_W:0]           rnd;
  logic [HI_W-1:0]        hi;
  logic [LEVEL_W-1:0]     lvl_scaled, level_nxt, level_r;

  // frame length clamped to 1..MAX_FRAME_LEN
  always_comb begin
    if (frame_len_r == '0) begin
      eff_len = LEN_W'(1);
    end else if (32'(frame_len_r) > 32'(MAX_FRAME_LEN)) begin
      eff_len = LEN_W'(MAX_FRAME_LEN);
    end else begin
      eff_len = LEN_W'(frame_len_r);
    end
  end

  assign idx_inc = {1'b0, idx_r} + 1'b1;
  assign mag     = sample[SAMPLE_BITS-1] ? (~sample + 1'b1) : sample;

  always_comb begin
    acc_nxt = acc_r;
    if (cfg_wr_en || cmd.emit) begin
      acc_nxt = '0;
    end else if (sq_vld_r) begin
      acc_nxt = acc_r + SUM_W'(sq_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_len_r <= FRAME_LEN_RST;
      idx_r       <= '0;
      sq_vld_r    <= 1'b0;
      acc_r       <= '0;
    end else begin
      acc_r    <= acc_nxt;
      sq_vld_r <= cmd.take && !cfg_wr_en;
      if (cfg_wr_en) begin
        frame_len_r <= cfg_wr_data;
        idx_r       <= '0;
      end else if (cmd.take) begin
        idx_r <= sts.last ? '0 : idx_inc[LEN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      sq_r <= SQ_W'(mag) * SQ_W'(mag);
    end
    if (cmd.chk) begin
      zero_r <= sts.sum_zero;
      full_r <= sts.sum_full;
    end
  end

  // shared log2 unit, first for the frame length then for the sum
  assign lg_cmd.load  = cmd.ld_len || cmd.ld_sum;
  assign lg_cmd.shift = cmd.shift;
  assign lg_cmd.iter  = cmd.iter;
  assign lg_val       = cmd.ld_sum ? NORM_W'(acc_r) : NORM_W'(eff_len);

  fal_log2 #(
    .NORM_W (NORM_W)
  ) u_log2 (
    .clk       (clk),
    .cmd       (lg_cmd),
    .load_val  (lg_val),
    .norm_done (lg_norm),
    .result    (lg_res)
  );

  assign num = D_W'(l_len_r) + (D_W'(FS_SHIFT) << FRAC_BITS);
  assign den = D_W'(lg_res);

  always_ff @(posedge clk) begin
    if (cmd.save_len) begin
      l_len_r <= lg_res;
    end
    if (cmd.diff) begin
      d_r <= (num > den) ? (num - den) : '0;
    end
    if (cmd.mul) begin
      v_r <= V_W'(d_r) * V_W'(LOG_K);
    end
    if (cmd.emit) begin
      level_r <= level_nxt;
    end
  end

  // round half up at the binary point, saturate at silence
  always_comb begin
    rnd = (V_W + 1)'(v_r) + ((V_W + 1)'(1) << (RND_POS - 1));
    hi  = rnd[V_W:RND_POS];
    if (hi > HI_W'(LEVEL_SILENT)) begin
      lvl_scaled = LEVEL_SILENT;
    end else begin
      lvl_scaled = LEVEL_W'(hi);
    end
    if (zero_r) begin
      level_nxt = LEVEL_SILENT;
    end else if (full_r) begin
      level_nxt = LEVEL_FULL;
    end else begin
      level_nxt = lvl_scaled;
    end
  end

  assign sts.last      = idx_inc >= {1'b0, eff_len};
  assign sts.sum_zero  = acc_r == '0;
  assign sts.sum_full  = acc_r >= {eff_len, {FS_SHIFT{1'b0}}};
  assign sts.norm_done = lg_norm;
  assign level_dbov    = level_r;

  a_idx_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, idx_r} < {1'b0, eff_len})
    else $error("sample index reached the frame length");

  a_emit_clears_sum: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> acc_r == '0)
    else $error("energy sum not cleared after level load");

  a_diff_not_special: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.diff |-> (!zero_r && !full_r))
    else $error("log path taken for a silent or full-scale frame");

endmodule
`default_nettype wire

### rtl/fal_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fal_ctrl
// frame sequencer: sample intake, frame-end log steps and output register
// ----------------------------------------------------------------------------
module fal_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  fal_pkg::fal_sts_t sts,
  output fal_pkg::fal_cmd_t cmd
);
  import fal_pkg::*;

  fal_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             op_sum_r, op_sum_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      cnt_r       <= '0;
      op_sum_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      op_sum_r    <= op_sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    op_sum_nxt = op_sum_r;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state_r)
      ST_RUN: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
        if (in_valid && sts.last) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        cmd.chk = 1'b1;
        if (sts.sum_zero || sts.sum_full) begin
          state_nxt = ST_OUT;
        end else begin
          cmd.ld_len = 1'b1;
          op_sum_nxt = 1'b0;
          state_nxt  = ST_NORM;
        end
      end
      ST_NORM: begin
        cnt_nxt = '0;
        if (sts.norm_done) begin
          state_nxt = ST_FRAC;
        end else begin
          cmd.shift = 1'b1;
        end
      end
      ST_FRAC: begin
        cmd.iter = 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == FRAC_LAST) begin
          state_nxt = op_sum_r ? ST_DIFF : ST_NEXT;
        end
      end
      ST_NEXT: begin
        cmd.save_len = 1'b1;
        cmd.ld_sum   = 1'b1;
        op_sum_nxt   = 1'b1;
        state_nxt    = ST_NORM;
      end
      ST_DIFF: begin
        cmd.diff  = 1'b1;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_RUN;
        end
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase
  end

  always_comb begin
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

  a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.take && sts.last) |=> !in_ready)
    else $error("intake still open after the last sample of a frame");

  a_frac_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FRAC) |-> (cnt_r <= FRAC_LAST))
    else $error("fraction counter ran past the last bit");

  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_valid_r)
    else $error("level loaded but output not valid");

endmodule
`default_nettype wire

### rtl/frame_audio_level_dbov_core.sv
`default_nettype none
// frame end: after the transfer of its last sample the last square is added, the sum is
//   checked, log2 of the frame length and of the sum is taken (NORM_W = 43 by default),
//   then the difference and the db scaling; silent and full-scale frames skip the log steps
// throughput: one sample per cycle inside a frame; the frame end holds intake until its
//   level is loaded, and the log2 unit normalizes one bit and finds one fraction bit per cycle, twice
// reset: synchronous active-low rst_n clears the sum, the sample count, the sequencer
//   and the output valid, and sets frame_length to 960
// ----------------------------------------------------------------------------
// frame_audio_level_dbov_core
// per-frame audio level in dbov from signed samples
// ----------------------------------------------------------------------------
module frame_audio_level_dbov_core #(
  parameter int MAX_FRAME_LEN = 4096,
  parameter int SAMPLE_BITS   = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // frame length register: the user must write it only while no frame is pending; the block does not enforce this
  input  logic                      cfg_wr_en,
  input  logic [fal_pkg::CFG_W-1:0] cfg_wr_data,
  // sample channel in, level channel out
  fal_sample_if.sink                in_if,
  fal_level_if.source               out_if
);
  import fal_pkg::*;

  fal_cmd_t cmd;
  fal_sts_t sts;

  // sequencer: opens intake during a frame, then walks the log steps and
  // loads the output register once the previous level has been taken
  fal_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: square and accumulate per transfer, shared log2 unit,
  // db scaling with rounding and the level register
  fal_dpath #(
    .MAX_FRAME_LEN (MAX_FRAME_LEN),
    .SAMPLE_BITS   (SAMPLE_BITS)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .sample      (in_if.sample),
    .cmd         (cmd),
    .sts         (sts),
    .level_dbov  (out_if.level_dbov)
  );

endmodule
`default_nettype wire
